// ----- rtl/core/chained_range_remap_min_defines.svh -----
// assertion macros for the remap chain
// no dependencies; included by the top level
`ifndef CHAINED_RANGE_REMAP_MIN_DEFINES_SVH
`define CHAINED_RANGE_REMAP_MIN_DEFINES_SVH

`ifndef ASSERT_OFF
`define CRRM_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define CRRM_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define CRRM_ASSERT(lbl, clk, rst, prop)
`define CRRM_ASSERT_NEVER(lbl, clk, rst, cond)
`endif

`endif

// ----- rtl/core/crrm_pkg.sv -----
// shared types and constants for the remap chain
// no dependencies; used by every module of the block
package crrm_pkg;

   localparam int NUM_STAGES        = 7;
   localparam int WINDOWS_PER_STAGE = 32;
   localparam int WIN_IDX_W         = (WINDOWS_PER_STAGE > 1) ? $clog2(WINDOWS_PER_STAGE) : 1;
   localparam int STAGE_W           = 3;
   localparam int SLOT_W            = 5;
   localparam int DATA_W            = 32;

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_SEED  = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type             cmd;
      logic [STAGE_W-1:0]  stage;
      logic [SLOT_W-1:0]   slot;
      logic [DATA_W-1:0]   dest_start;
      logic [DATA_W-1:0]   src_start;
      logic [DATA_W-1:0]   span;
      logic [DATA_W-1:0]   seed_value;
      logic                last_seed;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0]   location;
      logic [DATA_W-1:0]   lowest_so_far;
      logic                run_done;
      logic                overlap_seen;
   } rsp_type;

   typedef struct packed {
      req_type             req;
      logic                multi;
   } cell_item_type;

endpackage

// ----- rtl/core/crrm_cell.sv -----
// one remap stage: window store, parallel match and translate, item register
// depends on crrm_pkg
module crrm_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic [crrm_pkg::STAGE_W-1:0]  stage_id,
   input  logic                          in_valid,
   input  crrm_pkg::cell_item_type       in_item,
   output logic                          out_valid,
   output crrm_pkg::cell_item_type       out_item
);
   import crrm_pkg::*;

   logic [WINDOWS_PER_STAGE-1:0] win_valid_ff, win_valid_in;
   logic [DATA_W-1:0]            src_ff  [WINDOWS_PER_STAGE];
   logic [DATA_W:0]              end_ff  [WINDOWS_PER_STAGE];
   logic [DATA_W-1:0]            base_ff [WINDOWS_PER_STAGE];
   logic                         out_valid_ff;
   cell_item_type                out_item_ff, out_item_in;

   logic                         wr_en;
   logic [WIN_IDX_W-1:0]         wr_idx;
   logic [DATA_W:0]              wr_end_in;
   logic [DATA_W-1:0]            wr_base_in;
   logic [WINDOWS_PER_STAGE-1:0] hit;
   logic [DATA_W-1:0]            base_sel;
   logic                         multi_hit;

   assign wr_en = adv && in_valid && (in_item.req.cmd == CMD_WRITE)
                  && (in_item.req.stage == stage_id)
                  && (int'(in_item.req.slot) < WINDOWS_PER_STAGE);
   assign wr_idx     = WIN_IDX_W'(in_item.req.slot);
   assign wr_end_in  = {1'b0, in_item.req.src_start} + {1'b0, in_item.req.span};
   assign wr_base_in = in_item.req.dest_start - in_item.req.src_start;

   always_comb begin
      win_valid_in = win_valid_ff;
      if (wr_en) begin
         win_valid_in[wr_idx] = 1'b1;
      end
   end

   // window w covers x when src <= x < src + span
   always_comb begin
      base_sel = '0;
      for (int w = 0; w < WINDOWS_PER_STAGE; w++) begin
         hit[w] = win_valid_ff[w] && (in_item.req.seed_value >= src_ff[w])
                  && ({1'b0, in_item.req.seed_value} < end_ff[w]);
         if (hit[w]) begin
            base_sel = base_ff[w];
         end
      end
   end

   assign multi_hit = (hit & (hit - WINDOWS_PER_STAGE'(1))) != '0;

   always_comb begin
      out_item_in = in_item;
      if (in_item.req.cmd == CMD_SEED) begin
         if (hit != '0) begin
            out_item_in.req.seed_value = in_item.req.seed_value + base_sel;
         end
         out_item_in.multi = in_item.multi | multi_hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_valid_ff <= '0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         win_valid_ff <= win_valid_in;
         out_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_item_ff <= out_item_in;
      end
      if (wr_en) begin
         src_ff[wr_idx]  <= in_item.req.src_start;
         end_ff[wr_idx]  <= wr_end_in;
         base_ff[wr_idx] <= wr_base_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_item  = out_item_ff;

endmodule

// ----- rtl/core/crrm_tail.sv -----
// end of the chain: running minimum and result register
// depends on crrm_pkg
module crrm_tail (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  crrm_pkg::cell_item_type  in_item,
   output logic                     adv,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output crrm_pkg::rsp_type        rsp_item
);
   import crrm_pkg::*;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_item_ff, rsp_item_in;
   logic [DATA_W-1:0]  min_ff, min_in;
   logic [DATA_W-1:0]  min_cand;
   logic               load;

   assign adv  = !rsp_valid_ff || rsp_ready;
   assign load = adv && in_valid && (in_item.req.cmd == CMD_SEED);

   always_comb begin
      min_cand = (in_item.req.seed_value < min_ff) ? in_item.req.seed_value : min_ff;
      min_in   = min_ff;
      if (load) begin
         min_in = in_item.req.last_seed ? '1 : min_cand;
      end
      rsp_valid_in = adv ? load : rsp_valid_ff;
      rsp_item_in.location      = in_item.req.seed_value;
      rsp_item_in.lowest_so_far = min_cand;
      rsp_item_in.run_done      = in_item.req.last_seed;
      rsp_item_in.overlap_seen  = in_item.multi;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         min_ff       <= '1;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         min_ff       <= min_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ----- rtl/core/chained_range_remap_min.sv -----
// path: a seed item passes every stage cell in order and then the result register, which
// holds its result; write items pass the same cells and give no result
// throughput: one item per cycle; the whole cell chain holds while a result waits
// reset: clears window valid marks, cell valids and the result valid; running minimum
// goes to all ones; window contents are undefined until written; no item taken in reset
module chained_range_remap_min (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  crrm_pkg::req_type  req_item,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output crrm_pkg::rsp_type  rsp_item
);
   import crrm_pkg::*;

   `include "chained_range_remap_min_defines.svh"

   logic           adv;
   logic           chain_valid [NUM_STAGES+1];
   cell_item_type  chain_item  [NUM_STAGES+1];

   assign chain_valid[0]      = req_valid;
   assign chain_item[0].req   = req_item;
   assign chain_item[0].multi = 1'b0;
   assign req_ready           = adv && !reset;

   for (genvar s = 0; s < NUM_STAGES; s++) begin : g_cell
      crrm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .stage_id  (STAGE_W'(s)),
         .in_valid  (chain_valid[s]),
         .in_item   (chain_item[s]),
         .out_valid (chain_valid[s+1]),
         .out_item  (chain_item[s+1])
      );
   end

   crrm_tail u_tail (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain_valid[NUM_STAGES]),
      .in_item   (chain_item[NUM_STAGES]),
      .adv       (adv),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   `CRRM_ASSERT_NEVER(a_min_above_loc, clock, reset, rsp_valid && (rsp_item.lowest_so_far > rsp_item.location))
   `CRRM_ASSERT_NEVER(a_stall_cause, clock, reset, !req_ready && !(rsp_valid && !rsp_ready))
   `CRRM_ASSERT(a_stall_holds, clock, reset, (rsp_valid && !rsp_ready) |=> $stable(rsp_item.lowest_so_far))

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// self-checking testbench for the chained remap block with running minimum
// depends on crrm_pkg and chained_range_remap_min; needs no files or arguments
module testbench;
   import crrm_pkg::*;

   localparam int TOTAL_ITEMS = 950;
   localparam int HOLD_AFTER  = 250;
   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 40;
   localparam int STALL_LIMIT = 4000;

   typedef struct {
      req_type item;
      int      gap;
      bit      drain;
   } backlog_entry;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_item  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_item;

   backlog_entry req_backlog[$];
   backlog_entry head;
   rsp_type      due_results[$];
   rsp_type      want;

   logic [DATA_W-1:0] win_dest  [NUM_STAGES][WINDOWS_PER_STAGE];
   logic [DATA_W-1:0] win_src   [NUM_STAGES][WINDOWS_PER_STAGE];
   logic [DATA_W-1:0] win_span  [NUM_STAGES][WINDOWS_PER_STAGE];
   bit                win_valid [NUM_STAGES][WINDOWS_PER_STAGE] = '{default: 1'b0};
   logic [DATA_W-1:0] run_low = '1;

   int queued_count   = 0;
   int accepted_count = 0;
   int fail_count     = 0;
   int idle_cycles    = 0;
   int send_wait      = 0;
   bit send_calm      = 1'b1;
   int rx_wait        = 0;
   int rx_stretch     = 0;
   bit rx_calm        = 1'b1;
   bit hold_done      = 1'b0;

   chained_range_remap_min i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // window writes update the tables, seeds walk every stage and queue a result
   function automatic void apply_remap_item(req_type it);
      logic [DATA_W-1:0] x;
      logic [DATA_W-1:0] y;
      logic [DATA_W-1:0] off;
      logic              multi;
      int                hits;
      rsp_type           res;
      if (it.cmd == CMD_WRITE) begin
         if (it.stage < NUM_STAGES && it.slot < WINDOWS_PER_STAGE) begin
            win_dest[it.stage][it.slot]  = it.dest_start;
            win_src[it.stage][it.slot]   = it.src_start;
            win_span[it.stage][it.slot]  = it.span;
            win_valid[it.stage][it.slot] = 1'b1;
         end
         return;
      end
      x     = it.seed_value;
      multi = 1'b0;
      for (int s = 0; s < NUM_STAGES; s++) begin
         y    = x;
         hits = 0;
         for (int w = 0; w < WINDOWS_PER_STAGE; w++) begin
            if (win_valid[s][w] && x >= win_src[s][w]) begin
               off = x - win_src[s][w];
               if (off < win_span[s][w]) begin
                  hits++;
                  y = win_dest[s][w] + off;
               end
            end
         end
         if (hits > 1) multi = 1'b1;
         x = y;
      end
      if (x < run_low) run_low = x;
      res.location      = x;
      res.lowest_so_far = run_low;
      res.run_done      = it.last_seed;
      res.overlap_seen  = multi;
      due_results = {due_results, res};
      if (it.last_seed) run_low = '1;
   endfunction

   function automatic req_type window_item(int stage, int slot, logic [DATA_W-1:0] dest,
                                           logic [DATA_W-1:0] src, logic [DATA_W-1:0] span);
      req_type it;
      it.cmd        = CMD_WRITE;
      it.stage      = STAGE_W'(stage);
      it.slot       = SLOT_W'(slot);
      it.dest_start = dest;
      it.src_start  = src;
      it.span       = span;
      it.seed_value = $urandom;
      it.last_seed  = 1'($urandom_range(0, 1));
      return it;
   endfunction

   function automatic req_type seed_item(logic [DATA_W-1:0] value, logic last);
      req_type it;
      it.cmd        = CMD_SEED;
      it.stage      = STAGE_W'($urandom_range(0, 7));
      it.slot       = SLOT_W'($urandom_range(0, 31));
      it.dest_start = $urandom;
      it.src_start  = $urandom;
      it.span       = $urandom;
      it.seed_value = value;
      it.last_seed  = last;
      return it;
   endfunction

   task automatic queue_item(req_type it, bit drain);
      backlog_entry e;
      e.item  = it;
      e.drain = drain;
      e.gap   = (send_calm || $urandom_range(0, 99) >= 30) ? 0 : pick_gap();
      req_backlog = {req_backlog, e};
      if (it.cmd == CMD_SEED || it.stage < NUM_STAGES) queued_count++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
      end else begin
         if (req_valid && req_ready) begin
            apply_remap_item(req_item);
            accepted_count++;
         end
         if (!req_valid || req_ready) begin
            if (req_backlog.size() == 0) begin
               req_valid <= 1'b0;
            end else if (send_wait < req_backlog[0].gap) begin
               send_wait++;
               req_valid <= 1'b0;
            end else if (req_backlog[0].drain && due_results.size() != 0) begin
               req_valid <= 1'b0;
            end else begin
               head = req_backlog.pop_front();
               req_item  <= head.item;
               req_valid <= 1'b1;
               send_wait = 0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected result: location %h lowest %h done %b overlap %b",
                           rsp_item.location, rsp_item.lowest_so_far,
                           rsp_item.run_done, rsp_item.overlap_seen);
               fail_count++;
            end else begin
               want = due_results.pop_front();
               if (rsp_item.location !== want.location ||
                   rsp_item.lowest_so_far !== want.lowest_so_far ||
                   rsp_item.run_done !== want.run_done ||
                   rsp_item.overlap_seen !== want.overlap_seen) begin
                  if (fail_count < 10)
                     $display("mismatch exp/act: loc %h/%h low %h/%h done %b/%b ovl %b/%b",
                              want.location, rsp_item.location,
                              want.lowest_so_far, rsp_item.lowest_so_far,
                              want.run_done, rsp_item.run_done,
                              want.overlap_seen, rsp_item.overlap_seen);
                  fail_count++;
               end
            end
         end
         if (rx_stretch == 0) begin
            rx_stretch = $urandom_range(40, 300);
            rx_calm    = ($urandom_range(0, 3) == 0);
         end else begin
            rx_stretch--;
         end
         if (!hold_done && accepted_count >= HOLD_AFTER) begin
            hold_done = 1'b1;
            rx_wait   = HOLD_CYCLES;
         end
         if (rx_wait > 0) begin
            rx_wait--;
            rsp_ready <= 1'b0;
         end else if (!rx_calm && $urandom_range(0, 99) < 30) begin
            rx_wait = pick_gap() - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [DATA_W-1:0] base;
      logic [DATA_W-1:0] span;
      logic [DATA_W-1:0] dest;
      req_type           it;
      int                phase;
      int                count;
      bit                drain;

      // directed: empty tables, overlap, ignored stage, wrap, zero span, rewrite
      queue_item(seed_item(32'h0, 1'b0), 1'b0);
      queue_item(seed_item(32'hFFFF_FFFF, 1'b1), 1'b0);
      queue_item(window_item(0, 0, 32'h1000, 32'h0, 32'h100), 1'b0);
      queue_item(window_item(0, 1, 32'h2000, 32'h80, 32'h100), 1'b0);
      queue_item(window_item(NUM_STAGES, 2, 32'h0, 32'h0, 32'hFFFF_FFFF), 1'b0);
      queue_item(window_item(6, 31, 32'hFFFF_FFF0, 32'hFFFF_FF00, 32'hFFFF_FFFF), 1'b0);
      queue_item(window_item(3, 5, 32'h0, 32'h1000, 32'h0), 1'b0);
      queue_item(window_item(2, 0, 32'hFFFF_FFFF, 32'h2000, 32'h1), 1'b0);
      queue_item(seed_item(32'h80, 1'b0), 1'b0);
      queue_item(seed_item(32'h7F, 1'b0), 1'b0);
      queue_item(seed_item(32'hFF, 1'b0), 1'b0);
      queue_item(seed_item(32'h100, 1'b0), 1'b0);
      queue_item(seed_item(32'h1000, 1'b0), 1'b0);
      queue_item(seed_item(32'hFFFF_FFFF, 1'b0), 1'b0);
      queue_item(window_item(0, 0, 32'h3000, 32'h0, 32'h10), 1'b0);
      queue_item(seed_item(32'h5, 1'b0), 1'b0);
      queue_item(seed_item(32'h20, 1'b1), 1'b0);
      queue_item(window_item(5, 16, 32'h0, 32'hFFFF_FFFF, 32'h1), 1'b0);
      queue_item(seed_item(32'hFFFF_FFFF, 1'b1), 1'b0);

      phase = 0;
      while (queued_count < TOTAL_ITEMS) begin
         phase++;
         send_calm = ($urandom_range(0, 3) == 0);
         drain     = (phase == 3) || ($urandom_range(0, 5) == 0);
         case ($urandom_range(0, 3))
            0: base = 32'h0;
            1: base = 32'hFFFF_F000;
            default: base = $urandom;
         endcase
         if ($urandom_range(0, 9) == 0) begin
            count = $urandom_range(10, 30);
            for (int i = 0; i < count; i++) begin
               it.cmd        = cmd_type'($urandom_range(0, 1));
               it.stage      = STAGE_W'($urandom_range(0, 7));
               it.slot       = SLOT_W'($urandom_range(0, 31));
               it.dest_start = $urandom;
               it.src_start  = $urandom;
               it.span       = $urandom;
               it.seed_value = $urandom;
               it.last_seed  = 1'($urandom_range(0, 1));
               queue_item(it, drain && i == 0);
            end
         end else begin
            count = $urandom_range(2, 14);
            for (int i = 0; i < count; i++) begin
               case ($urandom_range(0, 19))
                  0: span = 32'h0;
                  1: span = $urandom;
                  default: span = $urandom_range(1, 1024);
               endcase
               dest = ($urandom_range(0, 9) == 0) ? $urandom : base + $urandom_range(0, 4095);
               queue_item(window_item(($urandom_range(0, 19) == 0) ? 7 : $urandom_range(0, 6),
                                      ($urandom_range(0, 2) == 0) ? $urandom_range(0, 31)
                                                                  : $urandom_range(0, 3),
                                      dest, base + $urandom_range(0, 4095), span),
                          drain && i == 0);
            end
            count = $urandom_range(8, 40);
            for (int i = 0; i < count; i++)
               queue_item(seed_item(($urandom_range(0, 9) == 0) ? $urandom
                                                                : base + $urandom_range(0, 4095),
                                    ($urandom_range(0, 9) == 0) ||
                                    (i == count - 1 && $urandom_range(0, 1) == 0)), 1'b0);
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      while (req_backlog.size() != 0 || req_valid || due_results.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/crrm_pkg.sv
rtl/core/crrm_cell.sv
rtl/core/crrm_tail.sv
rtl/core/chained_range_remap_min.sv
tb/sv/testbench.sv
